/* sv/ctwd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the compressed text word decoder.
package ctwd_pkg;

    localparam int SPACE_COUNT_WIDTH_DEF = 16;
    localparam int WORD_BYTES            = 6;
    localparam int BYTE_W                = 8;
    localparam int WORD_W                = WORD_BYTES * BYTE_W;
    localparam int IDX_W                 = $clog2(WORD_BYTES);
    localparam int CODE_W                = 7;
    localparam int OUT_SPACES_W          = 16;

    localparam logic [BYTE_W-1:0] CODE_NEWLINE  = 8'd10;
    localparam logic [BYTE_W-1:0] CODE_SPACE    = 8'd32;
    localparam logic [BYTE_W-1:0] CODE_RUN_BASE = 8'o200;
    localparam logic [BYTE_W-1:0] BYTE_MASK     = 8'hFF;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    typedef enum logic [1:0] {
        CLS_RUN,
        CLS_SPACE,
        CLS_CHAR,
        CLS_NEWLINE
    } byte_class_t;

    typedef struct packed {
        byte_class_t         cls;
        logic [CODE_W-1:0]   val;
        logic                last;
    } byte_entry_t;

    typedef struct packed {
        logic                          title;
        byte_entry_t [WORD_BYTES-1:0]  bytes;
    } word_entry_t;

endpackage

/* sv/ctwd_if.sv */
`timescale 1ns / 1ps
// Word and result channel interfaces for the compressed text word decoder.
interface ctwd_word_if;
    logic                               valid;
    logic                               ready;
    logic [ctwd_pkg::WORD_W-1:0]        packed_word;
    logic                               title_marker;

    modport source (output valid, output packed_word, output title_marker, input ready);
    modport sink   (input valid, input packed_word, input title_marker, output ready);
endinterface

interface ctwd_result_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [ctwd_pkg::OUT_SPACES_W-1:0]  leading_spaces;
    logic [ctwd_pkg::CODE_W-1:0]        char_code;
    logic                               last;

    modport source (output valid, output kind, output leading_spaces, output char_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input leading_spaces, input char_code,
                    input last, output ready);
endinterface

/* sv/compressed_text_word_decoder.sv */
`timescale 1ns / 1ps
// Top level of the compressed text word decoder: front end, queue, back end.
// Each request on words carries six text codes and is classified on entry and parked in a
// two-entry queue, so words are taken while the back end is still busy. The back end walks
// one code per cycle unless a result is stalled: a full word is walked to its sixth code, a
// word ended by a newline up to and including the newline, and a title-marker word is popped
// without a walk. A result leaves through the queue entry and then an output register, and a
// stalled result holds the walk only at codes that give a result.
module compressed_text_word_decoder #(
    parameter int SPACE_COUNT_WIDTH = ctwd_pkg::SPACE_COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ctwd_word_if.sink     words,
    ctwd_result_if.source results
);

    logic                  push;
    logic                  full;
    logic                  pop;
    logic                  q_valid;
    ctwd_pkg::word_entry_t push_data;
    ctwd_pkg::word_entry_t q_data;

    ctwd_front u_front (
        .words     (words),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    ctwd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .rd_valid  (q_valid),
        .rd_data   (q_data)
    );

    ctwd_back #(
        .SPACE_COUNT_WIDTH (SPACE_COUNT_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .results (results)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (words.valid && words.ready && !q_valid) |=> q_valid)
        else $error("accepted word did not reach the queue");

    a_eol_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.kind == ctwd_pkg::KIND_EOL)) |->
            ((results.leading_spaces == '0) && (results.char_code == '0) && results.last))
        else $error("end-of-line result carries bad fields");

endmodule

/* sv/ctwd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts words, classifies each code and marks the last result.
module ctwd_front (
    ctwd_word_if.sink              words,
    input  logic                   full,
    output logic                   push,
    output ctwd_pkg::word_entry_t  push_data
);

    logic [ctwd_pkg::BYTE_W-1:0]     code [ctwd_pkg::WORD_BYTES];
    logic [ctwd_pkg::WORD_BYTES-1:0] has_result;
    logic [ctwd_pkg::WORD_BYTES-1:0] result_after;

    assign words.ready = !full;
    assign push        = words.valid && !full;

    always_comb
    begin
        push_data       = '0;
        push_data.title = words.title_marker;
        for (int i = 0; i < ctwd_pkg::WORD_BYTES; i++)
        begin
            code[i] = words.packed_word[ctwd_pkg::WORD_W-1-ctwd_pkg::BYTE_W*i -: ctwd_pkg::BYTE_W]
                      & ctwd_pkg::BYTE_MASK;
            push_data.bytes[i].val = code[i][ctwd_pkg::CODE_W-1:0];
            if (code[i] == ctwd_pkg::CODE_NEWLINE)
            begin
                push_data.bytes[i].cls = ctwd_pkg::CLS_NEWLINE;
            end
            else if (code[i] >= ctwd_pkg::CODE_RUN_BASE)
            begin
                push_data.bytes[i].cls = ctwd_pkg::CLS_RUN;
            end
            else if (code[i] == ctwd_pkg::CODE_SPACE)
            begin
                push_data.bytes[i].cls = ctwd_pkg::CLS_SPACE;
            end
            else
            begin
                push_data.bytes[i].cls = ctwd_pkg::CLS_CHAR;
            end
            has_result[i] = (push_data.bytes[i].cls == ctwd_pkg::CLS_CHAR) ||
                            (push_data.bytes[i].cls == ctwd_pkg::CLS_NEWLINE);
        end

        // result_after[i]: some later code in the word also gives a result
        result_after[ctwd_pkg::WORD_BYTES-1] = 1'b0;
        for (int i = ctwd_pkg::WORD_BYTES - 2; i >= 0; i--)
        begin
            result_after[i] = result_after[i+1] || has_result[i+1];
        end

        for (int i = 0; i < ctwd_pkg::WORD_BYTES; i++)
        begin
            push_data.bytes[i].last = has_result[i] &&
                ((push_data.bytes[i].cls == ctwd_pkg::CLS_NEWLINE) || !result_after[i]);
        end
    end

endmodule

/* sv/ctwd_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue between the classifying front end and the decoding back end.
module ctwd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ctwd_pkg::word_entry_t  push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   rd_valid,
    output ctwd_pkg::word_entry_t  rd_data
);

    ctwd_pkg::word_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/ctwd_back.sv */
`timescale 1ns / 1ps
// Back end: walks one code per cycle unless a result stalls, keeps the pending space count, drives results.
module ctwd_back #(
    parameter int SPACE_COUNT_WIDTH = ctwd_pkg::SPACE_COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  ctwd_pkg::word_entry_t  q_data,
    output logic                   pop,
    ctwd_result_if.source          results
);

    localparam int W     = SPACE_COUNT_WIDTH;
    localparam int EXT_W = (W > ctwd_pkg::OUT_SPACES_W) ? W : ctwd_pkg::OUT_SPACES_W;
    localparam logic [ctwd_pkg::IDX_W-1:0] LAST_IDX = ctwd_pkg::IDX_W'(ctwd_pkg::WORD_BYTES - 1);

    logic [W-1:0]                    pending_reg, pending_next;
    logic [ctwd_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            kind_reg;
    logic [ctwd_pkg::OUT_SPACES_W-1:0] spaces_reg;
    logic [ctwd_pkg::CODE_W-1:0]     code_reg;
    logic                            last_reg;

    ctwd_pkg::byte_entry_t           cur;
    logic [ctwd_pkg::CODE_W-1:0]     add_amt;
    logic [W:0]                      sum;
    logic [W-1:0]                    sat_sum;
    logic [EXT_W-1:0]                pending_ext;
    logic [ctwd_pkg::OUT_SPACES_W-1:0] spaces_out;
    logic                            out_free;
    logic                            is_result;
    logic                            step;
    logic                            load;

    assign results.valid          = out_valid_reg;
    assign results.kind           = kind_reg;
    assign results.leading_spaces = spaces_reg;
    assign results.char_code      = code_reg;
    assign results.last           = last_reg;

    always_comb
    begin
        cur       = q_data.bytes[idx_reg];
        add_amt   = (cur.cls == ctwd_pkg::CLS_SPACE) ? ctwd_pkg::CODE_W'(1) : cur.val;
        sum       = {1'b0, pending_reg} + (W+1)'(add_amt);
        // hold at all ones on overflow
        sat_sum   = sum[W] ? {W{1'b1}} : sum[W-1:0];

        pending_ext = EXT_W'(pending_reg);
        spaces_out  = (pending_ext > EXT_W'({ctwd_pkg::OUT_SPACES_W{1'b1}})) ?
                      {ctwd_pkg::OUT_SPACES_W{1'b1}} : pending_ext[ctwd_pkg::OUT_SPACES_W-1:0];

        out_free  = !out_valid_reg || results.ready;
        is_result = (cur.cls == ctwd_pkg::CLS_CHAR) || (cur.cls == ctwd_pkg::CLS_NEWLINE);
        step      = q_valid && !q_data.title && (!is_result || out_free);
        load      = step && is_result;

        pending_next = pending_reg;
        idx_next     = idx_reg;
        pop          = 1'b0;

        if (q_valid && q_data.title)
        begin
            pending_next = '0;
            idx_next     = '0;
            pop          = 1'b1;
        end
        else if (step)
        begin
            case (cur.cls)
                ctwd_pkg::CLS_RUN,
                ctwd_pkg::CLS_SPACE:   pending_next = sat_sum;
                ctwd_pkg::CLS_CHAR,
                ctwd_pkg::CLS_NEWLINE: pending_next = '0;
                default:               pending_next = pending_reg;
            endcase
            // newline skips the rest of the word
            if ((cur.cls == ctwd_pkg::CLS_NEWLINE) || (idx_reg == LAST_IDX))
            begin
                idx_next = '0;
                pop      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        out_valid_next = load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (cur.cls == ctwd_pkg::CLS_NEWLINE)
            begin
                kind_reg   <= ctwd_pkg::KIND_EOL;
                spaces_reg <= '0;
                code_reg   <= '0;
            end
            else
            begin
                kind_reg   <= ctwd_pkg::KIND_CHAR;
                spaces_reg <= spaces_out;
                code_reg   <= cur.val;
            end
            last_reg <= cur.last;
        end
    end

endmodule

/* sim/compressed_text_word_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the compressed text word decoder: random and directed words.
module compressed_text_word_decoder_test;

    import ctwd_pkg::*;

    localparam int SPACES_W     = SPACE_COUNT_WIDTH_DEF;
    localparam int RANDOM_WORDS = 62;
    localparam int BLANK_BURST  = 90;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 30;
    localparam int REPORT_MAX   = 10;

    localparam logic [SPACES_W-1:0]     SPACES_CAP     = {SPACES_W{1'b1}};
    localparam logic [OUT_SPACES_W-1:0] OUT_SPACES_MAX = {OUT_SPACES_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] bits;
        logic              title;
    } word_req_t;

    typedef struct packed {
        logic                    kind;
        logic [OUT_SPACES_W-1:0] spaces;
        logic [CODE_W-1:0]       code;
        logic                    last;
    } text_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic              word_valid = 1'b0;
    logic [WORD_W-1:0] word_bits  = '0;
    logic              word_title = 1'b0;
    logic              result_ready = 1'b0;

    word_req_t    pending_words [$];
    text_result_t expected_text [$];
    logic [SPACES_W-1:0] blank_count;

    int error_count = 0;
    int word_gap;
    int ready_gap;
    int word_calm   = 0;
    int result_calm = 0;

    ctwd_word_if   word_ch ();
    ctwd_result_if result_ch ();

    assign word_ch.valid        = word_valid;
    assign word_ch.packed_word  = word_bits;
    assign word_ch.title_marker = word_title;
    assign result_ch.ready      = result_ready;

    compressed_text_word_decoder #(
        .SPACE_COUNT_WIDTH(SPACES_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (word_ch),
        .results(result_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        else if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void add_blanks(input int unsigned n);
        longint unsigned sum;
        sum = blank_count;
        sum += n;
        if (sum >= SPACES_CAP)
            blank_count = SPACES_CAP;
        else
            blank_count = SPACES_W'(sum);
    endfunction

    // Walk the six codes of one request and queue the text results it should yield.
    function automatic void decode_word(input logic [WORD_W-1:0] bits, input logic title);
        text_result_t            found [WORD_BYTES];
        int                      n;
        logic [BYTE_W-1:0]       c;
        logic                    line_done;
        logic [OUT_SPACES_W-1:0] out_spaces;
        n = 0;
        line_done = 1'b0;
        if (title)
        begin
            blank_count = '0;
            return;
        end
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            c = bits[WORD_W-1-BYTE_W*i -: BYTE_W];
            if (!line_done)
            begin
                if (c == CODE_NEWLINE)
                begin
                    // drop trailing blanks and skip the rest of the word
                    blank_count = '0;
                    found[n] = '{KIND_EOL, '0, '0, 1'b0};
                    n++;
                    line_done = 1'b1;
                end
                else if (c >= CODE_RUN_BASE)
                    add_blanks(c - CODE_RUN_BASE);
                else if (c == CODE_SPACE)
                    add_blanks(1);
                else
                begin
                    if (blank_count > OUT_SPACES_MAX)
                        out_spaces = OUT_SPACES_MAX;
                    else
                        out_spaces = OUT_SPACES_W'(blank_count);
                    found[n] = '{KIND_CHAR, out_spaces, c[CODE_W-1:0], 1'b0};
                    n++;
                    blank_count = '0;
                end
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_text.push_back(found[i]);
    endfunction

    function automatic void queue_word(input logic [WORD_W-1:0] bits, input logic title);
        word_req_t req;
        req.bits  = bits;
        req.title = title;
        pending_words.push_back(req);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_code(input bit blanks_only);
        logic [BYTE_W-1:0] c;
        int r;
        r = blanks_only ? $urandom_range(0, 47) : $urandom_range(0, 99);
        if (r < 30)
            c = CODE_RUN_BASE + BYTE_W'($urandom_range(0, 127));
        else if (r < 48)
            c = CODE_SPACE;
        else if (r < 56)
            c = CODE_NEWLINE;
        else
        begin
            do
                c = BYTE_W'($urandom_range(0, 127));
            while (c == CODE_NEWLINE || c == CODE_SPACE);
        end
        return c;
    endfunction

    function automatic void queue_random_word();
        logic [WORD_W-1:0] bits;
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            bits = WORD_W'({$urandom, $urandom});
        else
        begin
            for (int i = 0; i < WORD_BYTES; i++)
                bits[WORD_W-1-BYTE_W*i -: BYTE_W] = pick_code(r >= 85);
        end
        queue_word(bits, ($urandom_range(0, 99) < 5));
    endfunction

    // Word driver: hold the request until taken, then idle for a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            word_bits  <= '0;
            word_title <= 1'b0;
            word_gap    = 0;
            blank_count = '0;
        end
        else
        begin
            if (word_ch.valid && word_ch.ready)
            begin
                decode_word(word_bits, word_title);
                void'(pending_words.pop_front());
                word_gap = pick_gap(word_calm);
            end
            if (!word_ch.valid || word_ch.ready)
            begin
                if (word_gap > 0)
                begin
                    word_gap--;
                    word_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    word_valid <= 1'b1;
                    word_bits  <= pending_words[0].bits;
                    word_title <= pending_words[0].title;
                end
                else
                    word_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each taken result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        text_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_gap = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_text.size() == 0)
                    note_error($sformatf("unexpected result kind=%0b spaces=%0d code=%0h last=%0b",
                        result_ch.kind, result_ch.leading_spaces, result_ch.char_code,
                        result_ch.last));
                else
                begin
                    want = expected_text.pop_front();
                    if (result_ch.kind !== want.kind || result_ch.leading_spaces !== want.spaces
                        || result_ch.char_code !== want.code || result_ch.last !== want.last)
                        note_error($sformatf({"mismatch: expected kind=%0b spaces=%0d code=%0h ",
                            "last=%0b, got kind=%0b spaces=%0d code=%0h last=%0b"},
                            want.kind, want.spaces, want.code, want.last, result_ch.kind,
                            result_ch.leading_spaces, result_ch.char_code, result_ch.last));
                end
                ready_gap = pick_gap(result_calm);
            end
            if (ready_gap > 0)
            begin
                ready_gap--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        int spins;
        int target;

        // every code zero: control code zero taken as a character
        queue_word('0, 1'b0);
        // all ones: six maximal blank runs, no result
        queue_word({WORD_W{1'b1}}, 1'b0);
        queue_word({8'h41, CODE_NEWLINE, {4{8'h42}}}, 1'b0);
        // run code with zero length adds nothing
        queue_word({CODE_RUN_BASE, 8'h41, {4{CODE_RUN_BASE}}}, 1'b0);
        // trailing blanks before a newline are dropped
        queue_word({CODE_SPACE, CODE_SPACE, CODE_RUN_BASE + 8'd5, CODE_NEWLINE,
                    8'h41, 8'h42}, 1'b0);
        queue_word({CODE_NEWLINE, {5{8'h43}}}, 1'b0);
        queue_word({8'h41, 8'h42, 8'h43, 8'h44, 8'h45, CODE_NEWLINE}, 1'b0);
        queue_word({8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46}, 1'b0);
        queue_word({CODE_SPACE, CODE_SPACE, CODE_SPACE, 8'h41, CODE_RUN_BASE + 8'd2, 8'h42},
                   1'b0);
        // blank-only word carries its count into the next word
        queue_word({CODE_SPACE, CODE_RUN_BASE + 8'd3, CODE_RUN_BASE, CODE_SPACE,
                    8'hFF, CODE_SPACE}, 1'b0);
        queue_word({8'h7F, {5{CODE_RUN_BASE}}}, 1'b0);
        // title marker clears the count and yields nothing
        queue_word({6{CODE_RUN_BASE + 8'd3}}, 1'b0);
        queue_word({CODE_NEWLINE, 8'h41, {4{8'h42}}}, 1'b1);
        queue_word({8'h41, {5{CODE_RUN_BASE}}}, 1'b0);
        queue_word({WORD_W{1'b1}}, 1'b1);
        queue_word({8'h01, 8'h09, 8'h0B, 8'h1F, 8'h7F, 8'h00}, 1'b0);
        queue_word({CODE_NEWLINE, CODE_NEWLINE, {4{CODE_SPACE}}}, 1'b0);

        // long blank burst drives the count into saturation, then keeps adding
        for (int i = 0; i < BLANK_BURST; i++)
            queue_word({WORD_W{1'b1}}, 1'b0);
        queue_word({CODE_SPACE, 8'h41, 8'hFF, CODE_SPACE, 8'h42, 8'h43}, 1'b0);

        target = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < target)
            queue_random_word();

        while (!rst_n || pending_words.size() != 0)
            @(posedge clk);
        spins = 0;
        while (expected_text.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_text.size() != 0)
            note_error($sformatf("%0d expected results never arrived", expected_text.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
